// ----- hdl/rrts_pkg.sv -----
`timescale 1ns / 1ps
package rrts_pkg;
  localparam int ID_W = 32;
  typedef enum logic [2:0] {
    OP_ADD = 3'd0, OP_KILL = 3'd1, OP_YIELD = 3'd2, OP_TICK = 3'd3, OP_FIND = 3'd4
  } op_t;
  typedef enum logic [1:0] {
    TS_READY = 2'd0, TS_RUNNING = 2'd1, TS_BLOCKED = 2'd2, TS_TERMINATED = 2'd3
  } tstate_t;
  typedef enum logic [1:0] {
    PL_FREE = 2'd0, PL_QUEUE = 2'd1, PL_ZOMBIE = 2'd2
  } place_t;
  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_NOT_FOUND = 2'd1, ST_FULL = 2'd2
  } status_t;
  typedef enum logic [4:0] {
    S_IDLE, S_ADD_SCAN, S_LK_Q, S_LK_Z, S_KILL_DEC, S_UL_WALK, S_UL_FIX,
    S_CN_FIND, S_CN_WALK, S_CN_HEAD, S_YIELD_DO, S_DONE
  } fsm_t;
endpackage

// ----- hdl/rrts_if.sv -----
`timescale 1ns / 1ps
interface rrts_in_if;
  import rrts_pkg::*;
  logic valid;
  logic ready;
  logic [2:0] operation;
  logic [ID_W-1:0] task_id;
  logic [1:0] initial_state;
  modport source (output valid, operation, task_id, initial_state, input ready);
  modport sink (input valid, operation, task_id, initial_state, output ready);
endinterface

interface rrts_out_if;
  import rrts_pkg::*;
  logic valid;
  logic ready;
  logic [1:0] status;
  logic [ID_W-1:0] running_id;
  logic running_valid;
  logic switched;
  logic resched_pending;
  logic [1:0] found_state;
  modport source (output valid, status, running_id, running_valid, switched,
                  resched_pending, found_state, input ready);
  modport sink (input valid, status, running_id, running_valid, switched,
                resched_pending, found_state, output ready);
endinterface

// ----- hdl/round_robin_task_scheduler.sv -----
`timescale 1ns / 1ps
// Round-robin task scheduler over a table of MAX_TASKS slots.
// Input channel in: operation (add, kill, yield, tick, find), task_id and
// initial_state, one beat per operation. Output channel out: one result beat
// per operation with status, running task, switch and reschedule flags and
// the state found by find.
// Quantum register: written by cfg_we/cfg_data, reset value 50. The user
// must write it only while idle; the block itself does not enforce this.
// One operation is handled at a time by a sequencer that walks the linked
// slot table one slot per cycle, so in.ready is low from acceptance until
// the result beat leaves. Kill does the lookup and the unlink walk, then,
// if it hit the running task, the round-robin walk; yield does only that.
// A stalled receiver holds the result in the output register; the block
// accepts nothing until it is taken.
// Reset clears the list heads, flags, tick phase and all slot place codes
// at once; the id, state and link arrays need no clearing.
module round_robin_task_scheduler #(
  parameter int MAX_TASKS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [15:0] cfg_data,
  rrts_in_if.sink in,
  rrts_out_if.source out
);
  import rrts_pkg::*;
  localparam int SW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = SW + 1;

  logic [ID_W-1:0] slot_task_id [MAX_TASKS];
  logic [1:0] slot_status [MAX_TASKS];
  logic [SW-1:0] slot_link [MAX_TASKS];
  logic [1:0] slot_place [MAX_TASKS];

  logic [SW-1:0] queue_head, queue_tail, zomb_top, running_slot;
  logic queue_nonempty, zombie_nonempty, running_present;
  logic [15:0] tick_phase, quantum_ticks;
  logic resched_flag;

  fsm_t state, state_next;
  logic [2:0] op;
  logic [ID_W-1:0] id;
  logic [1:0] init;
  logic [SW-1:0] cur, prev, tgt;
  logic has_prev, tgt_ok, sw_r;
  logic [CW-1:0] cnt;
  logic [SW-1:0] nxt;
  logic nxt_ok;
  logic [1:0] st_r, fs_r;

  // single shared walk step: where the queue goes after cur
  logic [SW-1:0] q_after;
  logic at_tail;
  logic cnt_end;
  assign at_tail = (cur == queue_tail);
  assign q_after = at_tail ? queue_head : slot_link[cur];
  assign cnt_end = (cnt == CW'(MAX_TASKS - 1));

  assign in.ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in.valid) begin
        case (in.operation)
          OP_ADD: state_next = S_ADD_SCAN;
          OP_KILL, OP_FIND: state_next = queue_nonempty ? S_LK_Q : S_LK_Z;
          OP_YIELD: state_next = S_CN_FIND;
          default: state_next = S_DONE;
        endcase
      end
      S_ADD_SCAN: if (slot_place[cur] == PL_FREE || cnt_end) state_next = S_DONE;
      S_LK_Q: if (slot_task_id[cur] == id) state_next = (op == OP_KILL) ? S_KILL_DEC : S_DONE;
        else if (at_tail || cnt_end) state_next = S_LK_Z;
      S_LK_Z: begin
        if (cnt == '0 && running_present && slot_task_id[running_slot] == id)
          state_next = (op == OP_KILL) ? S_KILL_DEC : S_DONE;
        else if (!zombie_nonempty) state_next = S_DONE;
        else if (slot_task_id[cur] == id)
          state_next = (op == OP_KILL) ? S_KILL_DEC : S_DONE;
        else if (slot_link[cur] == cur || cnt_end) state_next = S_DONE;
      end
      S_KILL_DEC: state_next = tgt_ok ? S_UL_WALK : S_DONE;
      S_UL_WALK: if (!queue_nonempty) state_next = S_UL_FIX;
        else if (cur == tgt || at_tail || cnt_end) state_next = S_UL_FIX;
      S_UL_FIX: state_next = (running_present && tgt == running_slot) ? S_CN_FIND : S_DONE;
      S_CN_FIND: begin
        if (!queue_nonempty || !running_present) state_next = S_YIELD_DO;
        else if (cur == running_slot) state_next = S_CN_WALK;
        else if (at_tail || cnt_end) state_next = S_CN_HEAD;
      end
      S_CN_WALK: if (cur == running_slot || slot_status[cur] == TS_READY || cnt_end)
        state_next = S_YIELD_DO;
      S_CN_HEAD: if (slot_status[cur] == TS_READY || at_tail || cnt_end)
        state_next = S_YIELD_DO;
      S_YIELD_DO: state_next = S_DONE;
      S_DONE: if (out.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out.valid = (state == S_DONE);
    out.status = st_r;
    out.running_id = running_present ? slot_task_id[running_slot] : '0;
    out.running_valid = running_present;
    out.switched = sw_r;
    out.resched_pending = resched_flag;
    out.found_state = fs_r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      queue_head <= '0; queue_tail <= '0; zomb_top <= '0; running_slot <= '0;
      queue_nonempty <= 1'b0; zombie_nonempty <= 1'b0; running_present <= 1'b0;
      tick_phase <= '0; resched_flag <= 1'b0; quantum_ticks <= 16'd50;
      for (int i = 0; i < MAX_TASKS; i++) slot_place[i] <= PL_FREE;
    end else begin
      state <= state_next;
      if (cfg_we) quantum_ticks <= cfg_data;
      case (state)
        S_IDLE: if (in.valid) begin
          op <= in.operation; id <= in.task_id; init <= in.initial_state;
          st_r <= ST_OK; fs_r <= TS_READY; sw_r <= 1'b0; cnt <= '0;
          tgt_ok <= 1'b0; nxt_ok <= 1'b0; has_prev <= 1'b0;
          cur <= (in.operation == OP_ADD) ? '0 :
                 (queue_nonempty && (in.operation != OP_YIELD)) ? queue_head :
                 (in.operation == OP_YIELD) ? queue_head : zomb_top;
          if (in.operation == OP_TICK) begin
            if (({1'b0, tick_phase} + 17'd1) >=
                ((quantum_ticks == '0) ? 17'd1 : {1'b0, quantum_ticks})) begin
              tick_phase <= '0; resched_flag <= 1'b1;
            end else tick_phase <= tick_phase + 16'd1;
          end
        end
        S_ADD_SCAN: begin
          if (slot_place[cur] == PL_FREE) begin
            slot_task_id[cur] <= id;
            slot_status[cur] <= (init == TS_TERMINATED) ? TS_BLOCKED : init;
            slot_place[cur] <= PL_QUEUE;
            slot_link[cur] <= cur;
            if (queue_nonempty) slot_link[queue_tail] <= cur;
            else queue_head <= cur;
            queue_tail <= cur;
            queue_nonempty <= 1'b1;
          end else if (cnt_end) st_r <= ST_FULL;
          cur <= cur + SW'(1); cnt <= cnt + CW'(1);
        end
        S_LK_Q: begin
          if (slot_task_id[cur] == id) begin
            tgt <= cur; fs_r <= slot_status[cur]; tgt_ok <= 1'b1;
          end else if (at_tail || cnt_end) begin
            cur <= zomb_top; cnt <= '0;
          end else begin
            cur <= slot_link[cur]; cnt <= cnt + CW'(1);
          end
        end
        S_LK_Z: begin
          if (cnt == '0 && running_present && slot_task_id[running_slot] == id) begin
            tgt <= running_slot; fs_r <= slot_status[running_slot]; tgt_ok <= 1'b1;
          end else if (!zombie_nonempty) begin
            st_r <= ST_NOT_FOUND;
          end else if (slot_task_id[cur] == id) begin
            tgt <= cur; fs_r <= slot_status[cur]; tgt_ok <= 1'b1;
          end else if (slot_link[cur] == cur || cnt_end) begin
            st_r <= ST_NOT_FOUND;
          end else begin
            cur <= slot_link[cur]; cnt <= cnt + CW'(1);
          end
          if (state_next == S_DONE && op == OP_FIND && !(cnt == '0 && running_present &&
              slot_task_id[running_slot] == id) && !(zombie_nonempty && slot_task_id[cur] == id))
            fs_r <= TS_READY;
        end
        S_KILL_DEC: begin
          fs_r <= TS_READY;
          if (!tgt_ok) st_r <= ST_NOT_FOUND;
          cur <= queue_head; cnt <= '0; has_prev <= 1'b0;
        end
        S_UL_WALK: begin
          if (queue_nonempty && cur == tgt) begin
            nxt_ok <= 1'b1;
            if (!has_prev) begin
              if (at_tail) queue_nonempty <= 1'b0;
              else queue_head <= slot_link[cur];
            end else begin
              slot_link[prev] <= slot_link[cur];
              if (at_tail) queue_tail <= prev;
            end
          end else begin
            prev <= cur; has_prev <= 1'b1;
            cur <= slot_link[cur]; cnt <= cnt + CW'(1);
          end
        end
        S_UL_FIX: begin
          // nxt_ok marks a successful unlink
          if (running_present && tgt == running_slot) begin
            slot_status[tgt] <= TS_TERMINATED;
            if (nxt_ok) begin
              slot_link[tgt] <= zombie_nonempty ? zomb_top : tgt;
              zomb_top <= tgt; zombie_nonempty <= 1'b1;
              slot_place[tgt] <= PL_ZOMBIE;
            end
          end else if (nxt_ok) begin
            slot_status[tgt] <= TS_TERMINATED;
            slot_place[tgt] <= PL_FREE;
          end else st_r <= ST_NOT_FOUND;
          nxt_ok <= 1'b0; cnt <= '0; cur <= queue_head;
        end
        S_CN_FIND: begin
          if (!queue_nonempty) nxt_ok <= 1'b0;
          else if (!running_present) begin nxt <= queue_head; nxt_ok <= 1'b1; end
          else if (cur == running_slot) begin cur <= q_after; cnt <= '0; end
          else if (at_tail || cnt_end) begin cur <= queue_head; cnt <= '0; end
          else begin cur <= slot_link[cur]; cnt <= cnt + CW'(1); end
        end
        S_CN_WALK: begin
          if (cur == running_slot) nxt_ok <= 1'b0;
          else if (slot_status[cur] == TS_READY) begin nxt <= cur; nxt_ok <= 1'b1; end
          else begin cur <= q_after; cnt <= cnt + CW'(1); end
        end
        S_CN_HEAD: begin
          if (slot_status[cur] == TS_READY) begin nxt <= cur; nxt_ok <= 1'b1; end
          else begin cur <= slot_link[cur]; cnt <= cnt + CW'(1); end
        end
        S_YIELD_DO: begin
          if (nxt_ok && !(running_present && nxt == running_slot)) begin
            resched_flag <= 1'b0; sw_r <= 1'b1;
            if (running_present && slot_status[running_slot] != TS_TERMINATED)
              slot_status[running_slot] <= TS_READY;
            slot_status[nxt] <= TS_RUNNING;
            running_slot <= nxt; running_present <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    out.valid |-> !in.ready) else $error("accept while result pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out.valid && !out.ready |=> out.valid && $stable(out.status))
    else $error("result dropped under stall");
  a_run: assert property (@(posedge clk) disable iff (rst)
    out.valid && out.switched |-> out.running_valid) else $error("switch w/o task");
`endif
endmodule

// ----- test/round_robin_task_scheduler_tb.sv -----
`timescale 1ns / 1ps
module round_robin_task_scheduler_tb;
  import rrts_pkg::*;

  localparam int NSLOT = 16;

  typedef struct packed {
    logic [2:0] op;
    logic [31:0] id;
    logic [1:0] init;
  } op_beat_t;

  typedef struct packed {
    logic [1:0] status;
    logic [31:0] run_id;
    logic run_valid;
    logic switched;
    logic resched;
    logic [1:0] found;
  } sched_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_data = '0;

  rrts_in_if in_ch ();
  rrts_out_if out_ch ();

  round_robin_task_scheduler dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in(in_ch.sink), .out(out_ch.source)
  );

  // scheduler shadow
  logic [31:0] m_id [NSLOT];
  tstate_t m_st [NSLOT];
  logic [3:0] m_link [NSLOT];
  place_t m_place [NSLOT];
  logic [3:0] q_head, q_tail, z_head, run_slot;
  logic q_ne, z_ne, run_ok;
  logic [15:0] phase, quantum;
  logic resched;

  op_beat_t pending_ops [$];
  sched_res_t expected_res [$];
  int errors = 0;
  int sent = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    errors++;
  endtask

  function automatic void shadow_reset();
    for (int i = 0; i < NSLOT; i++) begin
      m_place[i] = PL_FREE;
      m_id[i] = '0;
      m_st[i] = TS_READY;
      m_link[i] = '0;
    end
    q_head = 0; q_tail = 0; z_head = 0; run_slot = 0;
    q_ne = 0; z_ne = 0; run_ok = 0;
    phase = 0; resched = 0; quantum = 16'd50;
  endfunction

  function automatic logic [3:0] ring_next(input logic [3:0] s);
    return (s == q_tail) ? q_head : m_link[s];
  endfunction

  function automatic int find_slot(input logic [31:0] id);
    logic [3:0] c;
    if (q_ne) begin
      c = q_head;
      for (int n = 0; n < NSLOT; n++) begin
        if (m_id[c] == id) return int'(c);
        if (c == q_tail) break;
        c = m_link[c];
      end
    end
    if (run_ok && m_id[run_slot] == id) return int'(run_slot);
    if (z_ne) begin
      c = z_head;
      for (int n = 0; n < NSLOT; n++) begin
        if (m_id[c] == id) return int'(c);
        if (m_link[c] == c) break;
        c = m_link[c];
      end
    end
    return -1;
  endfunction

  function automatic bit unlink_slot(input logic [3:0] s);
    logic [3:0] c, p;
    bit has_p;
    if (!q_ne) return 0;
    c = q_head; p = 0; has_p = 0;
    for (int n = 0; n < NSLOT; n++) begin
      if (c == s) begin
        if (!has_p) begin
          if (c == q_tail) q_ne = 0;
          else q_head = m_link[c];
        end else begin
          m_link[p] = m_link[c];
          if (c == q_tail) q_tail = p;
        end
        return 1;
      end
      if (c == q_tail) break;
      p = c; has_p = 1;
      c = m_link[c];
    end
    return 0;
  endfunction

  function automatic int next_ready();
    logic [3:0] c;
    bit hit;
    if (!q_ne) return -1;
    if (!run_ok) return int'(q_head);
    c = q_head; hit = 0;
    for (int n = 0; n < NSLOT; n++) begin
      if (c == run_slot) begin hit = 1; break; end
      if (c == q_tail) break;
      c = m_link[c];
    end
    if (hit) begin
      c = ring_next(run_slot);
      for (int n = 0; n < NSLOT; n++) begin
        if (c == run_slot) return -1;
        if (m_st[c] == TS_READY) return int'(c);
        c = ring_next(c);
      end
      return -1;
    end
    c = q_head;
    for (int n = 0; n < NSLOT; n++) begin
      if (m_st[c] == TS_READY) return int'(c);
      if (c == q_tail) break;
      c = m_link[c];
    end
    return -1;
  endfunction

  function automatic bit switch_task();
    int nx;
    nx = next_ready();
    if (nx < 0) return 0;
    if (run_ok && nx == run_slot) return 0;
    resched = 0;
    if (run_ok && m_st[run_slot] != TS_TERMINATED) m_st[run_slot] = TS_READY;
    run_slot = 4'(nx);
    run_ok = 1;
    m_st[run_slot] = TS_RUNNING;
    return 1;
  endfunction

  function automatic sched_res_t apply_op(input op_beat_t b);
    sched_res_t r;
    int s;
    logic [16:0] nx, q;
    r = '0;
    case (b.op)
      OP_ADD: begin
        s = -1;
        for (int i = 0; i < NSLOT; i++)
          if (s < 0 && m_place[i] == PL_FREE) s = i;
        if (s < 0) r.status = ST_FULL;
        else begin
          m_id[s] = b.id;
          m_st[s] = tstate_t'((b.init > 2) ? 2'd2 : b.init);
          m_place[s] = PL_QUEUE;
          m_link[s] = 4'(s);
          if (q_ne) m_link[q_tail] = 4'(s);
          else q_head = 4'(s);
          q_tail = 4'(s);
          q_ne = 1;
        end
      end
      OP_KILL: begin
        s = find_slot(b.id);
        if (s < 0) r.status = ST_NOT_FOUND;
        else if (run_ok && s == run_slot) begin
          m_st[s] = TS_TERMINATED;
          if (unlink_slot(4'(s))) begin
            m_link[s] = z_ne ? z_head : 4'(s);
            z_head = 4'(s);
            z_ne = 1;
            m_place[s] = PL_ZOMBIE;
          end
          r.switched = switch_task();
        end else if (unlink_slot(4'(s))) begin
          m_st[s] = TS_TERMINATED;
          m_place[s] = PL_FREE;
        end else r.status = ST_NOT_FOUND;
      end
      OP_YIELD: r.switched = switch_task();
      OP_TICK: begin
        q = (quantum == 0) ? 17'd1 : {1'b0, quantum};
        nx = {1'b0, phase} + 17'd1;
        if (nx >= q) begin phase = 0; resched = 1; end
        else phase = nx[15:0];
      end
      OP_FIND: begin
        s = find_slot(b.id);
        if (s < 0) r.status = ST_NOT_FOUND;
        else r.found = m_st[s];
      end
      default: ;
    endcase
    r.run_id = run_ok ? m_id[run_slot] : '0;
    r.run_valid = run_ok;
    r.resched = resched;
    return r;
  endfunction

  // driver: bursts with random gaps
  int gap = 0;
  int burst = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) sent++;
      if (gap > 0) begin
        gap--;
        in_ch.valid <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        op_beat_t b;
        b = pending_ops.pop_front();
        expected_res.push_back(apply_op(b));
        in_ch.valid <= 1'b1;
        in_ch.operation <= b.op;
        in_ch.task_id <= b.id;
        in_ch.initial_state <= b.init;
        if (burst > 0) burst--;
        else begin
          burst = $urandom_range(0, 12);
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        end
      end else in_ch.valid <= 1'b0;
    end
  end

  // receiver stall pattern and checker
  int stall_cnt = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_res.size() == 0) report("result beat with nothing expected");
        else begin
          sched_res_t e;
          e = expected_res.pop_front();
          if (out_ch.status !== e.status)
            report($sformatf("status %0d exp %0d", out_ch.status, e.status));
          if (out_ch.running_id !== e.run_id)
            report($sformatf("running_id %h exp %h", out_ch.running_id, e.run_id));
          if (out_ch.running_valid !== e.run_valid)
            report($sformatf("running_valid %b exp %b", out_ch.running_valid, e.run_valid));
          if (out_ch.switched !== e.switched)
            report($sformatf("switched %b exp %b", out_ch.switched, e.switched));
          if (out_ch.resched_pending !== e.resched)
            report($sformatf("resched %b exp %b", out_ch.resched_pending, e.resched));
          if (out_ch.found_state !== e.found)
            report($sformatf("found_state %0d exp %0d", out_ch.found_state, e.found));
        end
      end
      stall_cnt++;
      case ((stall_cnt / 200) % 3)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 3) != 0);
        default: out_ch.ready <= ((stall_cnt % 7) < 2);
      endcase
    end
  end

  function automatic logic [31:0] pick_id();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: return $urandom_range(0, 11);
    endcase
  endfunction

  task automatic push_op(input logic [2:0] op, input logic [31:0] id,
                         input logic [1:0] init);
    op_beat_t b;
    b.op = op; b.id = id; b.init = init;
    pending_ops.push_back(b);
  endtask

  task automatic drain();
    wait (pending_ops.size() == 0 && !in_ch.valid);
    wait (expected_res.size() == 0);
    repeat (80) @(posedge clk);
  endtask

  task automatic set_quantum(input logic [15:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    quantum = v;
  endtask

  task automatic random_phase(input int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 28) push_op(OP_ADD, pick_id(), 2'($urandom_range(0, 3)));
      else if (r < 45) push_op(OP_KILL, pick_id(), 2'($urandom_range(0, 3)));
      else if (r < 65) push_op(OP_YIELD, pick_id(), 2'($urandom_range(0, 3)));
      else if (r < 82) push_op(OP_TICK, pick_id(), 2'($urandom_range(0, 3)));
      else if (r < 97) push_op(OP_FIND, pick_id(), 2'($urandom_range(0, 3)));
      else push_op(3'($urandom_range(5, 7)), $urandom(), 2'($urandom_range(0, 3)));
    end
  endtask

  initial begin
    shadow_reset();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: yield on empty, adds in every state, wrap, kills, full table
    push_op(OP_YIELD, 0, 0);
    push_op(OP_FIND, 32'hFFFF_FFFF, 0);
    push_op(OP_ADD, 32'h0, 2'd1);
    push_op(OP_ADD, 32'hFFFF_FFFF, 2'd0);
    push_op(OP_ADD, 32'h5, 2'd3);
    push_op(OP_ADD, 32'h5, 2'd2);
    push_op(OP_YIELD, 0, 0);
    push_op(OP_YIELD, 0, 0);
    push_op(OP_YIELD, 0, 0);
    push_op(OP_FIND, 32'h5, 0);
    push_op(OP_KILL, 32'h5, 0);
    push_op(OP_KILL, 32'hFFFF_FFFF, 0);
    push_op(OP_FIND, 32'hFFFF_FFFF, 0);
    push_op(OP_KILL, 32'hFFFF_FFFF, 0);
    push_op(OP_KILL, 32'h1234, 0);
    push_op(OP_TICK, 0, 0);
    push_op(3'd7, 32'hA5A5_A5A5, 2'd3);
    for (int i = 0; i < 15; i++) push_op(OP_ADD, 32'(i), 2'(i % 3));
    push_op(OP_FIND, 32'h3, 0);
    drain();

    set_quantum(16'd1);
    push_op(OP_TICK, 0, 0);
    push_op(OP_YIELD, 0, 0);
    random_phase(300);
    drain();

    set_quantum(16'd0);
    random_phase(300);
    drain();

    set_quantum(16'd3);
    random_phase(350);
    drain();

    set_quantum(16'hFFFF);
    random_phase(300);
    drain();

    if (errors == 0) $display("round_robin_task_scheduler_tb OK");
    else $display("round_robin_task_scheduler_tb NOT OK");
    $finish;
  end

  initial begin
    #20ms;
    $display("round_robin_task_scheduler_tb NOT OK");
    $finish;
  end
endmodule

// ----- filelist.f -----
hdl/rrts_pkg.sv
hdl/rrts_if.sv
hdl/round_robin_task_scheduler.sv
test/round_robin_task_scheduler_tb.sv
